### src/uscf_pkg.sv
package uscf_pkg;

    localparam logic [33:0] DOS_EPOCH_SECONDS = 34'd315532800;

    // reciprocal of 60 for 32-bit operands, product shifted right by 37
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;

    // floor(2^36 / 35064), quotient short by at most one
    localparam logic [20:0] RECIP_BLOCK  = 21'd1959829;
    localparam logic [20:0] HOURS_BLOCK  = 21'd35064;
    localparam logic [16:0] HOURS_BLOCK17 = 17'd35064;
    localparam logic [15:0] HOURS_LEAP   = 16'd8784;
    localparam logic [15:0] HOURS_NORMAL = 16'd8760;
    localparam logic [15:0] HOURS_TWO_NORMAL = 16'd17520;
    localparam logic [11:0] EPOCH_YEAR   = 12'd1980;

    // reciprocal of 3 for values below 2048, product shifted right by 11
    localparam logic [9:0] RECIP_3 = 10'd683;

    localparam logic [8:0] LEAP_DAY = 9'd60;

    // day of year before the first day of each month, normal year
    localparam logic [8:0] MONTH_BASE [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic        before_epoch;
        logic [20:0] hours;
        logic [5:0]  minute;
        logic [5:0]  second;
    } uscf_hms_t;

    typedef struct packed {
        logic        before_epoch;
        logic [11:0] year;
        logic [13:0] hour_of_year;
        logic [5:0]  minute;
        logic [5:0]  second;
    } uscf_yh_t;

    typedef struct packed {
        logic        before_epoch;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } uscf_fields_t;

endpackage

### src/uscf_tod.sv
module uscf_tod import uscf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        unix_seconds,
    input  logic signed [16:0] zone_offset,
    output logic               out_valid,
    output uscf_hms_t          out_hms
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic        b1_reg, b2_reg, b3_reg, b4_reg;
    logic [31:0] x1_reg, x2_reg;
    logic [63:0] p1_reg;
    logic [25:0] q3_reg, q4_reg;
    logic [5:0]  s3_reg, s4_reg;
    logic [63:0] p2_reg;
    uscf_hms_t   hms5_reg;

    logic [33:0] diff_next;
    logic [25:0] q1_next;
    logic [31:0] q1x60_next;
    logic [31:0] sec_full_next;
    logic [20:0] h_next;
    logic [25:0] hx60_next;
    logic [25:0] min_full_next;

    always_comb
    begin
        diff_next = {2'b00, unix_seconds} - DOS_EPOCH_SECONDS
                    - {{17{zone_offset[16]}}, zone_offset};
        q1_next = p1_reg[62:37];
        q1x60_next = ({6'b0, q1_next} << 6) - ({6'b0, q1_next} << 2);
        sec_full_next = x2_reg - q1x60_next;
        h_next = p2_reg[57:37];
        hx60_next = ({5'b0, h_next} << 6) - ({5'b0, h_next} << 2);
        min_full_next = q4_reg - hx60_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= diff_next[33];
            x1_reg <= diff_next[31:0];

            b2_reg <= b1_reg;
            x2_reg <= x1_reg;
            p1_reg <= {32'b0, x1_reg} * {32'b0, RECIP_60};

            b3_reg <= b2_reg;
            q3_reg <= q1_next;
            s3_reg <= sec_full_next[5:0];

            b4_reg <= b3_reg;
            q4_reg <= q3_reg;
            s4_reg <= s3_reg;
            p2_reg <= {38'b0, q3_reg} * {32'b0, RECIP_60};

            hms5_reg.before_epoch <= b4_reg;
            hms5_reg.hours        <= h_next;
            hms5_reg.minute       <= min_full_next[5:0];
            hms5_reg.second       <= s4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_hms   = hms5_reg;

endmodule

### src/uscf_year.sv
module uscf_year import uscf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  uscf_hms_t in_hms,
    output logic      out_valid,
    output uscf_yh_t  out_yh
);

    logic        v6_reg, v7_reg, v8_reg, v9_reg;

    uscf_hms_t   hms6_reg, hms7_reg, hms8_reg;
    logic [41:0] p3_reg;
    logic [4:0]  q7_reg, blk8_reg;
    logic [16:0] r7_reg;
    logic [15:0] r8_reg;
    uscf_yh_t    yh9_reg;

    logic [4:0]  q0_next;
    logic [20:0] r0_full_next;
    logic        over_next;
    logic [16:0] r_fix_next;
    logic [15:0] r2_next;
    logic [1:0]  yoff_next;
    logic [15:0] hy_next;
    logic [11:0] year_next;

    always_comb
    begin
        q0_next = p3_reg[40:36];
        r0_full_next = hms6_reg.hours - ({16'b0, q0_next} * HOURS_BLOCK);
        over_next = (r7_reg >= HOURS_BLOCK17);
        r_fix_next = r7_reg - HOURS_BLOCK17;
        r2_next = r8_reg - HOURS_LEAP;
        if (r8_reg >= HOURS_LEAP)
        begin
            if (r2_next >= HOURS_TWO_NORMAL)
            begin
                yoff_next = 2'd3;
                hy_next   = r2_next - HOURS_TWO_NORMAL;
            end
            else if (r2_next >= HOURS_NORMAL)
            begin
                yoff_next = 2'd2;
                hy_next   = r2_next - HOURS_NORMAL;
            end
            else
            begin
                yoff_next = 2'd1;
                hy_next   = r2_next;
            end
        end
        else
        begin
            yoff_next = 2'd0;
            hy_next   = r8_reg;
        end
        year_next = EPOCH_YEAR + {5'b0, blk8_reg, 2'b00} + {10'b0, yoff_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hms6_reg <= in_hms;
            p3_reg   <= {21'b0, in_hms.hours} * {21'b0, RECIP_BLOCK};

            hms7_reg <= hms6_reg;
            q7_reg   <= q0_next;
            r7_reg   <= r0_full_next[16:0];

            hms8_reg <= hms7_reg;
            blk8_reg <= over_next ? q7_reg + 5'd1 : q7_reg;
            r8_reg   <= over_next ? r_fix_next[15:0] : r7_reg[15:0];

            yh9_reg.before_epoch <= hms8_reg.before_epoch;
            yh9_reg.year         <= year_next;
            yh9_reg.hour_of_year <= hy_next[13:0];
            yh9_reg.minute       <= hms8_reg.minute;
            yh9_reg.second       <= hms8_reg.second;
        end
    end

    assign out_valid = v9_reg;
    assign out_yh    = yh9_reg;

endmodule

### src/uscf_date.sv
module uscf_date import uscf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  uscf_yh_t     in_yh,
    output logic         out_valid,
    output uscf_fields_t out_fields
);

    logic         v10_reg, v11_reg;

    uscf_yh_t     yh10_reg;
    logic [8:0]   doy10_reg;
    logic [4:0]   hour10_reg;
    uscf_fields_t f11_reg;

    logic [20:0]  pd_next;
    logic [8:0]   dq_next;
    logic [13:0]  dqx24_next;
    logic [13:0]  hour_full_next;
    logic         leap_next;
    logic [8:0]   doy_adj_next;
    logic [3:0]   cnt_next;
    logic [3:0]   month_next;
    logic [8:0]   day_full_next;
    uscf_fields_t f_next;

    always_comb
    begin
        pd_next = {10'b0, in_yh.hour_of_year[13:3]} * {11'b0, RECIP_3};
        dq_next = pd_next[19:11];
        dqx24_next = ({5'b0, dq_next} << 4) + ({5'b0, dq_next} << 3);
        hour_full_next = in_yh.hour_of_year - dqx24_next;
    end

    always_comb
    begin
        leap_next = (yh10_reg.year[1:0] == 2'b00);
        doy_adj_next = (leap_next && doy10_reg > LEAP_DAY) ? doy10_reg - 9'd1 : doy10_reg;
        cnt_next = 4'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (doy_adj_next > MONTH_BASE[i + 1])
            begin
                cnt_next = cnt_next + 4'd1;
            end
        end
        month_next = cnt_next + 4'd1;
        day_full_next = doy_adj_next - MONTH_BASE[cnt_next];
        if (leap_next && doy10_reg == LEAP_DAY)
        begin
            month_next = 4'd2;
            day_full_next = 9'd29;
        end

        f_next.before_epoch = yh10_reg.before_epoch;
        f_next.year   = yh10_reg.year;
        f_next.month  = month_next;
        f_next.day    = day_full_next[4:0];
        f_next.hour   = hour10_reg;
        f_next.minute = yh10_reg.minute;
        f_next.second = yh10_reg.second;
        if (yh10_reg.before_epoch)
        begin
            f_next = '0;
            f_next.before_epoch = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v10_reg <= in_valid;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yh10_reg   <= in_yh;
            doy10_reg  <= dq_next + 9'd1;
            hour10_reg <= hour_full_next[4:0];
            f11_reg    <= f_next;
        end
    end

    assign out_valid  = v11_reg;
    assign out_fields = f11_reg;

endmodule

### src/unix_seconds_to_calendar_fields.sv
// converts a 32-bit unsigned unix time to dos-epoch calendar fields after subtracting the
// zone offset; every year divisible by four counts as leap, so 2100 is wrong; times before
// 1980 give before_epoch in tuser and all-zero data; a fixed 11-stage pipeline of
// reciprocal multiplies (seconds, minutes, four-year blocks, days) takes one item per clock,
// and a stall on the output holds the whole pipeline in place
module unix_seconds_to_calendar_fields import uscf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        zone_offset_seconds_we,
    input  logic [16:0] zone_offset_seconds,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // unix_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // year, month, day, hour, minute, second, 2 zero bits
    output logic        m_axis_tuser    // before_epoch
);

    logic signed [16:0] zone_reg;
    logic               en;
    logic               hms_valid;
    uscf_hms_t          hms;
    logic               yh_valid;
    uscf_yh_t           yh;
    uscf_fields_t       fields;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
        end
        else if (zone_offset_seconds_we)
        begin
            zone_reg <= zone_offset_seconds;
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    uscf_tod u_tod (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .unix_seconds (s_axis_tdata),
        .zone_offset  (zone_reg),
        .out_valid    (hms_valid),
        .out_hms      (hms)
    );

    uscf_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hms_valid),
        .in_hms    (hms),
        .out_valid (yh_valid),
        .out_yh    (yh)
    );

    uscf_date u_date (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (yh_valid),
        .in_yh      (yh),
        .out_valid  (m_axis_tvalid),
        .out_fields (fields)
    );

    assign m_axis_tdata = {2'b00, fields.second, fields.minute, fields.hour,
                           fields.day, fields.month, fields.year};
    assign m_axis_tuser = fields.before_epoch;

endmodule

### src/uscf_checker.sv
module uscf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled item holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

    // input is only held off by a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

    // before the epoch all fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("nonzero fields with before_epoch");

    // fields stay within their calendar ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[15:12] != 4'd0 && m_axis_tdata[15:12] <= 4'd12
            && m_axis_tdata[20:16] != 5'd0 && m_axis_tdata[25:21] <= 5'd23
            && m_axis_tdata[31:26] <= 6'd59 && m_axis_tdata[37:32] <= 6'd59
            && m_axis_tdata[11:0] >= 12'd1980)
    else $error("calendar field out of range");

endmodule

bind unix_seconds_to_calendar_fields uscf_checker u_uscf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/unix_seconds_to_calendar_fields_tb.sv
`timescale 1ns / 100ps

module unix_seconds_to_calendar_fields_tb;

    localparam longint EPOCH_1980 = 64'sd315532800;
    localparam int DAY_SECONDS = 86400;
    localparam int PHASE_COUNT = 7;
    localparam int RANDOM_PER_PHASE = 185;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES = 30;
    localparam int MAX_REPORTS = 10;
    localparam longint CYCLE_LIMIT = 200000;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef enum int
    {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        logic        before_epoch;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_fields_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        zone_offset_seconds_we = 1'b0;
    logic [16:0] zone_offset_seconds = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [31:0]        stamps_pending [$];
    cal_fields_t        expected_fields [$];
    logic signed [16:0] zone_cfg = '0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 before_count = 0;
    int                 leap_day_count = 0;
    longint             cycles = 0;
    cal_fields_t        seen_fields;
    cal_fields_t        want_fields;

    unix_seconds_to_calendar_fields dut
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .zone_offset_seconds_we (zone_offset_seconds_we),
        .zone_offset_seconds    (zone_offset_seconds),
        .s_axis_tvalid          (s_axis_tvalid),
        .s_axis_tready          (s_axis_tready),
        .s_axis_tdata           (s_axis_tdata),
        .m_axis_tvalid          (m_axis_tvalid),
        .m_axis_tready          (m_axis_tready),
        .m_axis_tdata           (m_axis_tdata),
        .m_axis_tuser           (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic cal_fields_t calendar_of(logic [31:0] stamp, logic signed [16:0] shift);
        cal_fields_t r;
        longint shifted;
        longint x;
        longint yr;
        longint doy;
        int m;
        r = '0;
        shifted = longint'({32'd0, stamp}) - EPOCH_1980 - longint'(shift);
        if (shifted < 0)
        begin
            r.before_epoch = 1'b1;
            return r;
        end
        x = shifted;
        r.second = 6'(x % 60);
        x = x / 60;
        r.minute = 6'(x % 60);
        x = x / 60;
        yr = 1980 + 4 * (x / 35064);
        x = x % 35064;
        if (x >= 366 * 24)
        begin
            x = x - 366 * 24;
            yr = yr + 1 + x / (365 * 24);
            x = x % (365 * 24);
        end
        r.year = 12'(yr);
        r.hour = 5'(x % 24);
        doy = x / 24 + 1;
        if (yr % 4 == 0 && doy == 60)
        begin
            r.month = 4'd2;
            r.day = 5'd29;
            return r;
        end
        if (yr % 4 == 0 && doy > 60)
            doy = doy - 1;
        m = 0;
        while (m < 11 && MONTH_DAYS[m] < doy)
        begin
            doy = doy - MONTH_DAYS[m];
            m++;
        end
        r.month = 4'(m + 1);
        r.day = 5'(doy);
        return r;
    endfunction

    function automatic longint days_to_year(int years_after_1980);
        return longint'(years_after_1980) * 365 + (years_after_1980 + 3) / 4;
    endfunction

    // biased toward the epoch edge, day and year boundaries and leap days at this offset
    function automatic logic [31:0] random_stamp(longint shift);
        longint v;
        longint jitter;
        int y;
        v = 0;
        jitter = longint'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
                v = longint'($urandom);
            4, 5:
                v = EPOCH_1980 + shift + longint'($urandom_range(0, 400000)) - 200000;
            6, 7:
                v = EPOCH_1980 + shift + longint'($urandom_range(0, 46000)) * DAY_SECONDS
                    + jitter;
            8, 9:
            begin
                y = 4 * $urandom_range(0, 31);
                v = EPOCH_1980 + shift
                    + (days_to_year(y) + longint'($urandom_range(57, 61))) * DAY_SECONDS
                    + longint'($urandom_range(0, DAY_SECONDS - 1));
            end
            10:
            begin
                y = $urandom_range(0, 126);
                v = EPOCH_1980 + shift + days_to_year(y) * DAY_SECONDS + jitter;
            end
            default:
                v = ($urandom_range(0, 1) == 1) ? 64'hFFFF_FFFF - $urandom_range(0, 100)
                                                 : longint'($urandom_range(0, 100));
        endcase
        return v[31:0];
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_fields.push_back(calendar_of(s_axis_tdata, zone_cfg));
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stamps_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= stamps_pending.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_fields.before_epoch = m_axis_tuser;
                seen_fields.year = m_axis_tdata[11:0];
                seen_fields.month = m_axis_tdata[15:12];
                seen_fields.day = m_axis_tdata[20:16];
                seen_fields.hour = m_axis_tdata[25:21];
                seen_fields.minute = m_axis_tdata[31:26];
                seen_fields.second = m_axis_tdata[37:32];
                if (expected_fields.size() == 0)
                    note_mismatch("result with no item outstanding");
                else
                begin
                    want_fields = expected_fields.pop_front();
                    results_checked++;
                    if (want_fields.before_epoch)
                        before_count++;
                    if (want_fields.month == 4'd2 && want_fields.day == 5'd29)
                        leap_day_count++;
                    if (seen_fields.before_epoch !== want_fields.before_epoch
                        || seen_fields.year !== want_fields.year
                        || seen_fields.month !== want_fields.month
                        || seen_fields.day !== want_fields.day
                        || seen_fields.hour !== want_fields.hour
                        || seen_fields.minute !== want_fields.minute
                        || seen_fields.second !== want_fields.second)
                        note_mismatch($sformatf(
                            "exp %0d-%0d-%0d %0d:%0d:%0d be=%0d got %0d-%0d-%0d %0d:%0d:%0d be=%0d",
                            want_fields.year, want_fields.month, want_fields.day,
                            want_fields.hour, want_fields.minute, want_fields.second,
                            want_fields.before_epoch, seen_fields.year, seen_fields.month,
                            seen_fields.day, seen_fields.hour, seen_fields.minute,
                            seen_fields.second, seen_fields.before_epoch));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_fields.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] directed_stamps [21];
        logic signed [16:0] shift;
        idle_mode_t mode;
        directed_stamps = '{
            32'd0, 32'hFFFF_FFFF, 32'd315532799, 32'd315532800, 32'd320630399,
            32'd320630400, 32'd320716800, 32'd347155199, 32'd347155200, 32'd352252799,
            32'd352252800, 32'd441763200, 32'd951782400, 32'd2147483647, 32'd2147483648,
            32'd4007836799, 32'd4102444799, 32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555,
            32'd315532859
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: shift = 17'sd0;
                1: shift = 17'sd50400;
                2: shift = -17'sd50400;
                3: shift = 17'sh0FFFF;
                4: shift = 17'sh10000;
                5: shift = 17'($signed($urandom_range(0, 100800)) - 50400);
                default: shift = 17'($urandom);
            endcase
            mode = (ph < 2) ? IDLE_RX_HEAVY : (ph < 4) ? IDLE_TX_HEAVY : IDLE_NONE;
            // hold off until the pipeline is empty before touching the offset
            @(negedge clk);
            while (stamps_pending.size() > 0 || s_axis_tvalid || expected_fields.size() > 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            zone_offset_seconds_we <= 1'b1;
            zone_offset_seconds <= shift;
            @(posedge clk);
            zone_offset_seconds_we <= 1'b0;
            zone_cfg = shift;
            @(negedge clk);
            case (mode)
                IDLE_RX_HEAVY:
                begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 70;
                end
                IDLE_TX_HEAVY:
                begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 25;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (ph == 0)
                foreach (directed_stamps[i])
                    stamps_pending.push_back(directed_stamps[i]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                stamps_pending.push_back(random_stamp(longint'(shift)));
        end
        @(negedge clk);
        while (stamps_pending.size() > 0 || s_axis_tvalid || expected_fields.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_fields.size() > 0)
            note_mismatch("results missing at end of run");
        $display("%0d timestamps over %0d zone offsets, %0d results checked", items_sent,
                 PHASE_COUNT, results_checked);
        $display("%0d before 1980, %0d on a leap day, %0d mismatches", before_count,
                 leap_day_count, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
